@@ hdl/csm_pkg.sv @@
// ----------------------------------------------------------------------------
// csm_pkg: shared types and constants for the command slot manager
// Mode codes, field widths and the per-cell command struct.
// ----------------------------------------------------------------------------
`default_nettype none

package csm_pkg;

    localparam int SLOT_COUNT_DEF = 32;
    localparam int SLOT_IDX_W     = 5;
    localparam int MASK_W         = 32;
    localparam int MODE_W         = 3;
    localparam int IN_DATA_W      = 40;
    localparam int OUT_DATA_W     = 104;

    typedef enum logic [MODE_W-1:0] {
        MODE_RESERVE  = 3'd0,
        MODE_RELEASE  = 3'd1,
        MODE_ISSUE    = 3'd2,
        MODE_COMPLETE = 3'd3,
        MODE_ERROR    = 3'd4
    } mode_t;

    typedef struct packed {
        logic reserve;
        logic release_op;
        logic issue;
        logic complete;
        logic flush;
    } cell_cmd_t;

endpackage

`default_nettype wire

@@ hdl/csm_cell.sv @@
// ----------------------------------------------------------------------------
// csm_cell: one command slot
// Holds the reserved, issued, done and failure marks of a slot and passes the
// free-slot search on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module csm_cell #(
    parameter logic [csm_pkg::SLOT_IDX_W-1:0] SLOT_ID = '0
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  csm_pkg::cell_cmd_t                cmd,
    input  wire  [csm_pkg::SLOT_IDX_W-1:0]    slot_index,
    input  wire                               outstanding,
    input  wire                               search_in,
    output logic                              search_out,
    output logic                              grant,
    output logic                              issue_hit,
    output logic                              completed,
    output logic                              failed
);

    logic reserved_reg, reserved_next;
    logic issued_reg, issued_next;
    logic done_reg, done_next;
    logic failure_reg, failure_next;
    logic sel;

    assign sel        = (slot_index == SLOT_ID);
    assign search_out = search_in & reserved_reg;
    assign grant      = cmd.reserve & search_in & ~reserved_reg;
    assign issue_hit  = cmd.issue & sel;
    assign completed  = cmd.complete & issued_reg & ~outstanding;
    assign failed     = cmd.flush & issued_reg & ~done_reg;

    always_comb
    begin
        reserved_next = reserved_reg;
        issued_next   = issued_reg;
        done_next     = done_reg;
        failure_next  = failure_reg;
        if (grant)
        begin
            reserved_next = 1'b1;
        end
        if (cmd.release_op && sel)
        begin
            reserved_next = 1'b0;
            issued_next   = 1'b0;
            done_next     = 1'b0;
            failure_next  = 1'b0;
        end
        if (issue_hit)
        begin
            issued_next  = 1'b1;
            done_next    = 1'b0;
            failure_next = 1'b0;
        end
        if (completed)
        begin
            issued_next  = 1'b0;
            done_next    = 1'b1;
            failure_next = 1'b0;
        end
        if (failed)
        begin
            issued_next  = 1'b0;
            done_next    = 1'b1;
            failure_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_reg <= 1'b0;
            issued_reg   <= 1'b0;
            done_reg     <= 1'b0;
            failure_reg  <= 1'b0;
        end
        else
        begin
            reserved_reg <= reserved_next;
            issued_reg   <= issued_next;
            done_reg     <= done_next;
            failure_reg  <= failure_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/csm_enc.sv @@
// ----------------------------------------------------------------------------
// csm_enc: grant encoder
// Turns the one-hot grant vector of the cell row into a slot number.
// ----------------------------------------------------------------------------
`default_nettype none

module csm_enc #(
    parameter int SLOT_COUNT = csm_pkg::SLOT_COUNT_DEF
) (
    input  wire  [SLOT_COUNT-1:0]             onehot,
    output logic [csm_pkg::SLOT_IDX_W-1:0]    idx
);

    always_comb
    begin
        idx = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (onehot[i])
            begin
                idx = idx | csm_pkg::SLOT_IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/command_slot_manager.sv @@
// Each input transfer's result is registered and shown on the output in the cycle after the transfer.
// One event per cycle while the output is not stalled; the cell row updates every slot at once.
// The free-slot search ripples through the cell row within the cycle of the input transfer.
// Reset clears every slot mark and empties the output register; no sweep.
// ----------------------------------------------------------------------------
// command_slot_manager: command slot allocator and status tracker
// A row of slot cells handles reserve, release, issue, completion and error
// flush events; each result is held in an output register until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module command_slot_manager #(
    parameter int SLOT_COUNT = csm_pkg::SLOT_COUNT_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // mode[2:0], slot_index[7:3], outstanding_mask[39:8]
    input  wire  [csm_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // granted_slot[4:0], grant_valid[5], issue_bits[37:6],
    // completed_mask[69:38], failed_mask[101:70], zero[103:102]
    output logic [csm_pkg::OUT_DATA_W-1:0]     m_tdata
);

    logic                              accept;
    logic [csm_pkg::MODE_W-1:0]        mode;
    logic [csm_pkg::SLOT_IDX_W-1:0]    slot_index;
    logic [csm_pkg::MASK_W-1:0]        outstanding_mask;
    csm_pkg::cell_cmd_t                cmd;
    logic [SLOT_COUNT:0]               search;
    logic [SLOT_COUNT-1:0]             grant_vec;
    logic [SLOT_COUNT-1:0]             issue_vec;
    logic [SLOT_COUNT-1:0]             comp_vec;
    logic [SLOT_COUNT-1:0]             fail_vec;
    logic [csm_pkg::SLOT_IDX_W-1:0]    grant_idx;
    logic                              out_valid_reg;
    logic [csm_pkg::OUT_DATA_W-1:0]    out_data_reg, out_data_next;

    assign mode             = s_tdata[2:0];
    assign slot_index       = s_tdata[7:3];
    assign outstanding_mask = s_tdata[39:8];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        cmd = '0;
        unique case (mode)
            csm_pkg::MODE_RESERVE:  cmd.reserve    = accept;
            csm_pkg::MODE_RELEASE:  cmd.release_op = accept;
            csm_pkg::MODE_ISSUE:    cmd.issue      = accept;
            csm_pkg::MODE_COMPLETE: cmd.complete   = accept;
            csm_pkg::MODE_ERROR:    cmd.flush      = accept;
            default:                cmd = '0;
        endcase
    end

    assign search[0] = 1'b1;

    for (genvar g = 0; g < SLOT_COUNT; g++)
    begin : g_cell
        csm_cell #(
            .SLOT_ID(csm_pkg::SLOT_IDX_W'(g))
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .slot_index (slot_index),
            .outstanding(outstanding_mask[g]),
            .search_in  (search[g]),
            .search_out (search[g+1]),
            .grant      (grant_vec[g]),
            .issue_hit  (issue_vec[g]),
            .completed  (comp_vec[g]),
            .failed     (fail_vec[g])
        );
    end

    csm_enc #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_enc (
        .onehot(grant_vec),
        .idx   (grant_idx)
    );

    assign out_data_next = {2'b00,
                            csm_pkg::MASK_W'(fail_vec),
                            csm_pkg::MASK_W'(comp_vec),
                            csm_pkg::MASK_W'(issue_vec),
                            |grant_vec,
                            grant_idx};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_grant_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(grant_vec))
        else $error("more than one slot granted");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while result is stalled");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("transfer produced no result");

    a_single_event: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({|grant_vec, |issue_vec, |comp_vec, |fail_vec}))
        else $error("one event updated slots in several ways");
`endif

endmodule

`default_nettype wire
